// File: rtl/core/kpn_pkg.sv
`default_nettype none

package kpn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // column index, column count (can hold the width itself), row count, height
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  localparam int SCORE_W = 16;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t              SCORE_MIN       = 16'sh8000;
  localparam score_t              THRESHOLD_RESET = 16'sd61;
  localparam logic [SIZE_W-1:0]   WIDTH_RESET     = 11'd480;
  localparam logic [SIZE_W-1:0]   HEIGHT_RESET    = 11'd360;

  // one line store entry: the two previous rows at one column
  typedef struct packed {
    score_t mid;
    score_t up;
  } line_t;

  // an accepted item with its decision context
  typedef struct packed {
    logic [AW-1:0]      addr;
    logic               wrap;
    logic               left_ok;
    logic               top_ok;
    logic               bot_ok;
    logic               dec;
    logic               done;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    score_t             s;
  } item_t;

  typedef struct packed {
    logic               kp;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    score_t             score;
    logic               dec;
    logic               done;
  } result_t;

  function automatic score_t smax(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/kpn_line_store.sv
`default_nettype none

module kpn_line_store
  import kpn_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire line_t         wr_data,
  output line_t              rd_data
);

  line_t mem [MAX_WIDTH];
  line_t mem_q;
  line_t fwd_d;
  logic  fwd_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // a read of the entry being written in the same cycle takes the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_q <= 1'b0;
    end else if (rd_en) begin
      fwd_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) fwd_d <= wr_data;
  end

  assign rd_data = fwd_q ? fwd_d : mem_q;

endmodule

`default_nettype wire

// File: rtl/core/kpn_pos.sv
`default_nettype none

module kpn_pos
  import kpn_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          frame_start,
  input  wire logic          flush,
  input  wire score_t        score,
  input  wire logic [CW-1:0] w,
  input  wire logic [HW-1:0] h,
  output logic [AW-1:0]      rd_addr,
  output item_t              item
);

  logic [AW-1:0] column_count, column_next;
  logic [RW-1:0] row_count, row_next;

  logic [AW-1:0] c0, c;
  logic [RW-1:0] r0, r, hr, h2, ysel;
  logic [CW-1:0] cn, xsel;
  logic          wrap_in;
  item_t         item_next;

  always_comb begin
    hr = RW'(h);
    h2 = hr + RW'(2);
    c0 = frame_start ? '0 : column_count;
    r0 = frame_start ? '0 : row_count;
    // width lowered under a running frame: start the next row
    wrap_in = CW'(c0) >= w;
    c = wrap_in ? '0 : c0;
    r = (wrap_in && r0 < h2) ? r0 + RW'(1) : r0;

    cn = CW'(c) + CW'(1);
    if (cn >= w) begin
      column_next = '0;
      row_next    = (r < h2) ? r + RW'(1) : r;
    end else begin
      column_next = cn[AW-1:0];
      row_next    = r;
    end

    // column 0 closes the row two up, any other column decides its upper-left neighbour
    item_next.addr    = c;
    item_next.wrap    = (c == '0);
    ysel              = item_next.wrap ? r - RW'(2) : r - RW'(1);
    xsel              = item_next.wrap ? w - CW'(1) : CW'(c) - CW'(1);
    item_next.dec     = item_next.wrap ? (r >= RW'(2) && r < h2)
                                       : (r >= RW'(1) && r < hr + RW'(1));
    item_next.left_ok = item_next.wrap || (c >= AW'(2));
    item_next.top_ok  = (ysel != '0);
    item_next.bot_ok  = (ysel < hr - RW'(1));
    item_next.done    = item_next.wrap && (ysel == hr - RW'(1));
    item_next.x       = COORD_W'(xsel);
    item_next.y       = COORD_W'(ysel);
    item_next.s       = flush ? SCORE_MIN : score;
  end

  assign rd_addr = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= item_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/kpn_window.sv
`default_nettype none

module kpn_window
  import kpn_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire item_t  item,
  input  wire line_t  rd_line,
  input  wire score_t threshold,
  output result_t     result
);

  typedef struct packed {
    score_t top;
    score_t mid;
    score_t bot;
  } col_t;

  function automatic score_t col_max(input col_t col, input logic top_ok,
                                     input logic bot_ok);
    score_t t;
    score_t b;
    t = top_ok ? col.top : SCORE_MIN;
    b = bot_ok ? col.bot : SCORE_MIN;
    return smax(smax(col.mid, t), b);
  endfunction

  // two newest window columns; the oldest is never looked at again
  col_t   col1, col2, ncol;
  score_t lm, cm, rm;
  score_t lmax, cmax, rmax, centre;
  item_t  item2;
  score_t best;

  always_comb begin
    ncol.top = rd_line.up;
    ncol.mid = rd_line.mid;
    ncol.bot = item.s;
    lm = item.left_ok ? col_max(col1, item.top_ok, item.bot_ok) : SCORE_MIN;
    cm = col_max(col2, item.top_ok, item.bot_ok);
    rm = item.wrap ? SCORE_MIN : col_max(ncol, item.top_ok, item.bot_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col1 <= '0;
      col2 <= '0;
    end else if (shift) begin
      col1 <= col2;
      col2 <= ncol;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      lmax   <= lm;
      cmax   <= cm;
      rmax   <= rm;
      centre <= col2.mid;
      item2  <= item;
    end
  end

  always_comb begin
    best         = smax(smax(lmax, cmax), rmax);
    result.dec   = item2.dec;
    result.kp    = item2.dec && (centre > threshold) && (centre >= best);
    result.x     = item2.dec ? item2.x : '0;
    result.y     = item2.dec ? item2.y : '0;
    result.score = item2.dec ? centre : '0;
    result.done  = item2.dec && item2.done;
  end

endmodule

`default_nettype wire

// File: rtl/core/keypoint_threshold_nms_3x3_core.sv
// channel  direction  handshake            payload
// s_       in         s_tvalid / s_tready  tdata score, tuser frame_start, flush
// m_       out        m_tvalid / m_tready  tdata decision, tuser decision_valid,
//                                          tlast frame_done
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel a cycle sustained while the output is not stalled; a request
// passes the stages line store read, window and column maxima, final max.
// The line store is a single 32-bit wide memory, one read and one write a
// cycle; a read of the entry written in the same cycle is forwarded.
// Reset clears counters, window, stage valids and registers; the line store
// is not cleared. Input keeps being taken while the output stalls, until all
// three stages hold a request.
`default_nettype none

module keypoint_threshold_nms_3x3_core
  import kpn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,   // score
  input  wire logic [1:0]           s_tuser,   // frame_start, flush
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [39:0]               m_tdata,   // is_keypoint, key_x, key_y, key_score
  output logic [0:0]                m_tuser,   // decision_valid
  output logic                      m_tlast,   // frame_done
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  score_t            score_threshold;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic v1, v2;
  logic adv_out, adv2, adv1, accept;

  logic [AW-1:0] rd_addr;
  item_t         item1;
  line_t         rd_line, wr_line;
  result_t       result, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= THRESHOLD_RESET;
      image_width     <= WIDTH_RESET;
      image_height    <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: score_threshold <= cfg_data;
        REG_WIDTH:     image_width     <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:    image_height    <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < SIZE_W'(3))           w_eff = CW'(3);
    else if (32'(image_width) > MAX_WIDTH)  w_eff = CW'(MAX_WIDTH);
    else                                    w_eff = CW'(image_width);
    if (image_height < SIZE_W'(3))          h_eff = HW'(3);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                    h_eff = HW'(image_height);
  end

  // each stage moves when the one after it is empty or moving
  assign adv_out  = !m_tvalid || m_tready;
  assign adv2     = !v2 || adv_out;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;
  assign accept   = s_tvalid && adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1)    v1       <= accept;
      if (adv2)    v2       <= v1;
      if (adv_out) m_tvalid <= v2;
    end
  end

  kpn_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_tuser[0]),
    .flush       (s_tuser[1]),
    .score       (s_tdata),
    .w           (w_eff),
    .h           (h_eff),
    .rd_addr     (rd_addr),
    .item        (item1)
  );

  // the older row moves up, the new pixel becomes the middle row
  assign wr_line.up  = rd_line.mid;
  assign wr_line.mid = item1.s;

  kpn_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (v1 && adv2),
    .wr_addr (item1.addr),
    .wr_data (wr_line),
    .rd_data (rd_line)
  );

  kpn_window u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (v1 && adv2),
    .item      (item1),
    .rd_line   (rd_line),
    .threshold (score_threshold),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (adv_out && v2) out_res <= result;
  end

  assign m_tdata = {3'b000, out_res.score, out_res.y, out_res.x, out_res.kp};
  assign m_tuser = out_res.dec;
  assign m_tlast = out_res.done;

  a_addr_in_row: assert property (@(posedge clk) disable iff (rst)
    accept |-> (CW'(rd_addr) < w_eff))
    else $error("line store address beyond row width");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && m_tvalid))
    else $error("input stalled with a free stage");

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[0])
    else $error("frame end flagged without a decision");

  a_fwd_col0: assert property (@(posedge clk) disable iff (rst)
    (accept && v1 && adv2 && (rd_addr == item1.addr)) |-> (rd_addr == '0))
    else $error("back to back requests on one column away from column 0");

endmodule

`default_nettype wire

// File: verif/keypoint_threshold_nms_3x3_core_checker.sv
`timescale 1ns / 1ps

module keypoint_threshold_nms_3x3_core_checker
  import kpn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [15:0]          s_tdata,   // score
  input  wire logic [1:0]           s_tuser,   // frame_start, flush
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [39:0]          m_tdata,   // is_keypoint, key_x, key_y, key_score
  input  wire logic [0:0]           m_tuser,   // decision_valid
  input  wire logic                 m_tlast,   // frame_done
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  output int                        pending,
  output int                        fail_count
);

  localparam int REPORT_CAP = 40;

  score_t            thr;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  score_t line_up  [MAX_WIDTH];
  score_t line_mid [MAX_WIDTH];
  score_t win [3][3];
  int     col_n;
  int     row_n;

  result_t decisions_due [$];

  function automatic int fit_size(input logic [SIZE_W-1:0] raw, input int hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  // peak test on window column cc; neighbours off the image are skipped
  function automatic result_t judge(input int cc, input int x, input int y,
                                    input int w, input int h);
    result_t d;
    score_t  centre;
    score_t  best;
    int      nx;
    int      ny;
    int      k;
    centre = win[1][cc];
    best   = SCORE_MIN;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nx = x + dc;
        ny = y + dr;
        k  = cc + dc;
        if (k >= 0 && k <= 2 && nx >= 0 && nx < w && ny >= 0 && ny < h &&
            win[1+dr][k] > best) begin
          best = win[1+dr][k];
        end
      end
    end
    d       = '0;
    d.kp    = (centre > thr) && (centre >= best);
    d.x     = x[COORD_W-1:0];
    d.y     = y[COORD_W-1:0];
    d.score = centre;
    d.dec   = 1'b1;
    d.done  = (x == w - 1) && (y == h - 1);
    return d;
  endfunction

  task automatic shift_in_pixel(input score_t sc, input logic fs, input logic fl);
    int      w;
    int      h;
    int      c;
    int      r;
    score_t  s;
    score_t  up;
    score_t  md;
    result_t res;
    w = fit_size(width_reg, MAX_WIDTH);
    h = fit_size(height_reg, MAX_HEIGHT);
    s = fl ? SCORE_MIN : sc;
    if (fs) begin
      col_n = 0;
      row_n = 0;
    end
    if (col_n >= w) begin
      col_n = 0;
      if (row_n < h + 2) row_n++;
    end
    c   = col_n;
    r   = row_n;
    res = '0;
    // column 0: finish the last pixel of the row two up before shifting
    if (c == 0 && r - 2 >= 0 && r - 2 < h) res = judge(2, w - 1, r - 2, w, h);
    up = line_up[c];
    md = line_mid[c];
    line_up[c]  = md;
    line_mid[c] = s;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = md;
    win[2][2] = s;
    if (c != 0 && r - 1 >= 0 && r - 1 < h) res = judge(1, c - 1, r - 1, w, h);
    col_n = c + 1;
    if (col_n >= w) begin
      col_n = 0;
      if (row_n < h + 2) row_n++;
    end
    decisions_due.insert(decisions_due.size(), res);
  endtask

  task automatic report(input string name, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      if (fail_count < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      fail_count++;
    end
  endtask

  task automatic check_decision();
    result_t e;
    if (decisions_due.size() == 0) begin
      if (fail_count < REPORT_CAP)
        $display("%0t: decision with none due, expected nothing, got %h", $time, m_tdata);
      fail_count++;
    end else begin
      e = decisions_due[0];
      decisions_due.delete(0);
      report("is_keypoint", 16'(e.kp), 16'(m_tdata[0]));
      report("key_x", 16'(e.x), 16'(m_tdata[1 +: COORD_W]));
      report("key_y", 16'(e.y), 16'(m_tdata[1 + COORD_W +: COORD_W]));
      report("key_score", e.score, m_tdata[1 + 2 * COORD_W +: SCORE_W]);
      report("tdata padding", '0, 16'(m_tdata[39:37]));
      report("decision_valid", 16'(e.dec), 16'(m_tuser[0]));
      report("frame_done", 16'(e.done), 16'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr        = THRESHOLD_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_up[i]  = '0;
        line_mid[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      col_n = 0;
      row_n = 0;
      decisions_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr = score_t'(cfg_data);
          REG_WIDTH:     width_reg = cfg_data[SIZE_W-1:0];
          REG_HEIGHT:    height_reg = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) shift_in_pixel(score_t'(s_tdata), s_tuser[0], s_tuser[1]);
      if (m_tvalid && m_tready) check_decision();
    end
    pending = decisions_due.size();
  end

endmodule

// File: verif/keypoint_threshold_nms_3x3_core_test.sv
`timescale 1ns / 1ps

module keypoint_threshold_nms_3x3_core_test;
  import kpn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam score_t SCORE_TOP    = 16'sh7FFF;
  localparam int     RANDOM_ITEMS = 600;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  int                   pending;
  int                   fail_count;

  bit     tx_calm;
  bit     rx_calm;
  int     sent;
  score_t cur_thr;
  int     cur_w;
  int     cur_h;

  // peak in the centre, threshold-equal and below-threshold pixels in the last row
  score_t frame_a [9] = '{-16'sd32768, 16'sd100, 16'sd100,
                          16'sd100, 16'sh7FFF, 16'sd100,
                          16'sd5, 16'sd6, 16'sd1};
  // plateau of ties; first item is a flush pixel opening the frame
  score_t frame_b [9] = '{16'sd0, 16'sd7, 16'sd7,
                          16'sd7, 16'sd7, 16'sd6,
                          16'sd7, 16'sd7, 16'sd7};

  keypoint_threshold_nms_3x3_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  keypoint_threshold_nms_3x3_core_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  // receiver: random stall before each decision, ready held until taken
  initial begin
    int stall;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  function automatic int fit_size(input int raw, input int hi);
    int v;
    v = raw & 'h7FF;
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic score_t pick_score(input int mode, input score_t thr);
    int t;
    case (mode)
      1: t = int'(thr) + int'($urandom_range(0, 6)) - 3;
      2: t = int'(thr) + 1 + int'($urandom_range(0, 1));
      default: begin
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? SCORE_TOP : SCORE_MIN;
        return score_t'($urandom);
      end
    endcase
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return score_t'(t);
  endfunction

  function automatic score_t pick_threshold();
    case ($urandom_range(0, 5))
      0: return score_t'($urandom);
      1: return SCORE_MIN;
      2: return SCORE_TOP;
      3: return '0;
      default: return score_t'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic send_pixel(input score_t sc, input bit fs, input bit fl);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sc;
    s_tuser  <= {fl, fs};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // hold the input until every request has produced its decision
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input score_t thr, input int wraw, input int hraw, input bit spare);
    logic [15:0] wd;
    logic [15:0] hd;
    wd = 16'($urandom);
    hd = 16'($urandom);
    wd[SIZE_W-1:0] = wraw[SIZE_W-1:0];
    hd[SIZE_W-1:0] = hraw[SIZE_W-1:0];
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, hd);
    if (spare) write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_thr = thr;
    cur_w   = fit_size(wraw, MAX_WIDTH);
    cur_h   = fit_size(hraw, MAX_HEIGHT);
  endtask

  // one frame, sometimes cut short or restarted; full frames get the drain flushes
  task automatic send_frame(input int w, input int h, input int mode, input bit may_cut);
    int total;
    int cut;
    int tail;
    bit fs;
    bit fl;
    total = w * h;
    cut   = (may_cut && $urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
    for (int n = 0; n < cut; n++) begin
      fs = (n == 0) || (may_cut && $urandom_range(0, 99) == 0);
      fl = ($urandom_range(0, 29) == 0);
      send_pixel(pick_score(mode, cur_thr), fs, fl);
    end
    if (cut == total) begin
      // long tails run the row counter into its stop
      tail = w + 1 + (($urandom_range(0, 3) == 0) ? w + 2 : 0);
      for (int n = 0; n < tail; n++) send_pixel(score_t'($urandom), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int start;
    int wraw;
    int hraw;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    sent    = 0;
    cur_thr = THRESHOLD_RESET;
    cur_w   = WIDTH_RESET;
    cur_h   = HEIGHT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values in use: a row and a few pixels at the default size
    for (int n = 0; n < cur_w + 6; n++) send_pixel(pick_score(1, cur_thr), n == 0, 1'b0);

    configure(16'sd6, 3, 3, 1'b1);
    foreach (frame_a[i]) send_pixel(frame_a[i], i == 0, 1'b0);
    // next frame starts before the last row of the first is decided
    foreach (frame_b[i]) send_pixel(frame_b[i], i == 0, i == 0);
    repeat (8) send_pixel(score_t'($urandom), 1'b0, 1'b1);

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      if (sent == start || $urandom_range(0, 1) == 1) begin
        wraw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        hraw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        configure(pick_threshold(), wraw, hraw, $urandom_range(0, 3) == 0);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      send_frame(cur_w, cur_h, $urandom_range(0, 2), 1'b1);
    end

    // threshold extremes, each with one size clamped up from below
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    configure(SCORE_MIN, 10, 0, 1'b0);
    send_frame(cur_w, cur_h, 0, 1'b0);
    configure(SCORE_TOP, 0, 8, 1'b0);
    send_frame(cur_w, cur_h, 1, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/kpn_pkg.sv
rtl/core/kpn_line_store.sv
rtl/core/kpn_pos.sv
rtl/core/kpn_window.sv
rtl/core/keypoint_threshold_nms_3x3_core.sv
verif/keypoint_threshold_nms_3x3_core_checker.sv
verif/keypoint_threshold_nms_3x3_core_test.sv
